>>> design/jacobi_symbol_unit_defines.svh
// assertion helpers shared by the jacobi symbol unit modules
`ifndef JACOBI_SYMBOL_UNIT_DEFINES_SVH
`define JACOBI_SYMBOL_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define JSU_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("jsu check failed");

// next-cycle implication, checked at every rising clock edge outside reset
`define JSU_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("jsu check failed");

`endif

>>> design/jsu_pkg.sv
package jsu_pkg;

   // operand width and iteration counter width
   localparam int WIDTH = 32;
   localparam int IN_W  = 32;
   localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   // symbol codes, two's complement
   localparam logic [1:0] SYM_ZERO = 2'b00;
   localparam logic [1:0] SYM_POS  = 2'b01;
   localparam logic [1:0] SYM_NEG  = 2'b11;

   // residues that decide sign flips
   localparam logic [2:0] MOD8_THREE = 3'd3;
   localparam logic [2:0] MOD8_FIVE  = 3'd5;
   localparam logic [1:0] MOD4_THREE = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_STRIP
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic halve;
      logic swap;
      logic emit;
      logic emit_invalid;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic mod_bad;
      logic div_last;
      logic a_zero;
      logic a_even;
   } stat_type;

endpackage

>>> design/jsu_datapath.sv
`include "jacobi_symbol_unit_defines.svh"

module jsu_datapath
   import jsu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output stat_type        stat,
   input  logic [IN_W-1:0] req_numerator,
   input  logic [IN_W-1:0] req_modulus,
   output logic            rsp_strobe,
   output logic [1:0]      rsp_symbol,
   output logic            rsp_invalid
);

   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             strobe_ff, strobe_in;
   logic [1:0]       symbol_ff, symbol_in;
   logic             invalid_ff, invalid_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             fits;
   logic [WIDTH-1:0] rem_next;
   logic             div_last;
   logic             strip_flip;
   logic             swap_flip;

   // one restoring division step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial    = {rem_ff, a_ff[WIDTH-1]};
      diff     = trial - {1'b0, n_ff};
      fits     = (trial >= {1'b0, n_ff});
      rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      div_last = (cnt_ff == CNT_W'(WIDTH - 1));
   end

   // sign flip conditions
   assign strip_flip = (n_ff[2:0] == MOD8_THREE) || (n_ff[2:0] == MOD8_FIVE);
   assign swap_flip  = (a_ff[1:0] == MOD4_THREE) && (n_ff[1:0] == MOD4_THREE);

   // status to the controller
   always_comb begin
      stat.mod_bad  = (n_ff == '0) || !n_ff[0];
      stat.div_last = div_last;
      stat.a_zero   = (a_ff == '0);
      stat.a_even   = !a_ff[0];
   end

   // operand, divider and sign updates
   always_comb begin
      a_in   = a_ff;
      n_in   = n_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         a_in   = WIDTH'(req_numerator);
         n_in   = WIDTH'(req_modulus);
         neg_in = 1'b0;
      end
      if (cmd.div_start || cmd.swap) begin
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = rem_next;
         cnt_in = cnt_ff + CNT_W'(1);
         a_in   = div_last ? rem_next : {a_ff[WIDTH-2:0], 1'b0};
      end
      if (cmd.halve) begin
         a_in   = {1'b0, a_ff[WIDTH-1:1]};
         neg_in = neg_ff ^ strip_flip;
      end
      if (cmd.swap) begin
         a_in   = n_ff;
         n_in   = a_ff;
         neg_in = neg_ff ^ swap_flip;
      end
   end

   // result register
   always_comb begin
      strobe_in  = cmd.emit || cmd.emit_invalid;
      symbol_in  = symbol_ff;
      invalid_in = invalid_ff;
      if (cmd.emit_invalid) begin
         symbol_in  = SYM_ZERO;
         invalid_in = 1'b1;
      end else if (cmd.emit) begin
         invalid_in = 1'b0;
         if (n_ff == WIDTH'(1)) begin
            symbol_in = neg_ff ? SYM_NEG : SYM_POS;
         end else begin
            symbol_in = SYM_ZERO;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      n_ff       <= n_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      symbol_ff  <= symbol_in;
      invalid_ff <= invalid_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_symbol  = symbol_ff;
   assign rsp_invalid = invalid_ff;

   // partial remainder always stays below the modulus
   `JSU_ASSERT_NOW(a_rem_below_mod, cmd.div_step, rem_ff < n_ff)
   // the modulus stays odd while reducing
   `JSU_ASSERT_NOW(a_mod_odd_div, cmd.div_step || cmd.halve, n_ff[0])
   // a result never shows in consecutive cycles
   `JSU_ASSERT_NEXT(a_strobe_single, strobe_ff, !strobe_ff)

endmodule

>>> design/jsu_controller.sv
`include "jacobi_symbol_unit_defines.svh"

module jsu_controller
   import jsu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = stat.mod_bad ? ST_IDLE : ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_last) state_in = ST_STRIP;
         end
         ST_STRIP: begin
            priority if (stat.a_zero) state_in = ST_IDLE;
            else if (stat.a_even)     state_in = ST_STRIP;
            else                      state_in = ST_DIV;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_CHECK: begin
            cmd.emit_invalid = stat.mod_bad;
            cmd.div_start    = !stat.mod_bad;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_STRIP: begin
            priority if (stat.a_zero) cmd.emit  = 1'b1;
            else if (stat.a_even)     cmd.halve = 1'b1;
            else                      cmd.swap  = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // an accepted request always goes to the modulus check
   `JSU_ASSERT_NEXT(a_start_check, state_ff == ST_IDLE && start, state_ff == ST_CHECK)
   // the reduction runs its full count
   `JSU_ASSERT_NEXT(a_div_hold, state_ff == ST_DIV && !stat.div_last, state_ff == ST_DIV)
   // at most one datapath action per cycle besides the load
   `JSU_ASSERT_NOW(a_one_cmd, 1'b1,
      $onehot0({cmd.div_start, cmd.div_step, cmd.halve, cmd.swap, cmd.emit,
                cmd.emit_invalid}))

endmodule

>>> design/jacobi_symbol_unit.sv
// jacobi symbol unit: returns (numerator / modulus) as -1, 0 or 1.
// request: raise start with req_numerator and req_modulus; the request is
// taken on a rising edge where start is high and busy is low. busy stays
// high until the result has been issued, so one request is worked at a time.
// result: rsp_strobe is high for exactly one cycle with rsp_symbol (two's
// complement) and rsp_invalid; the receiver must take it then, no stall.
// an even or zero modulus gives rsp_invalid = 1 and symbol 0, issued from
// the check state. otherwise each reduction of the numerator modulo the
// modulus runs through a shared restoring divider, one quotient bit per
// cycle over all WIDTH dividend bits; each stripped factor of two and each
// swap takes one strip step. the number of reductions grows with log2 of
// the operands, and the divider loop sets the rate.
// a new request may be taken in the cycle the previous result is shown.
// reset (synchronous, active high) returns to idle and drops rsp_strobe.
module jacobi_symbol_unit
   import jsu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [IN_W-1:0] req_numerator,
   input  logic [IN_W-1:0] req_modulus,
   output logic            rsp_strobe,
   output logic signed [1:0] rsp_symbol,
   output logic            rsp_invalid
);

   cmd_type  cmd;
   stat_type stat;
   logic [1:0] symbol;

   // sequencing
   jsu_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // operands, divider and sign
   jsu_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_numerator (req_numerator),
      .req_modulus   (req_modulus),
      .rsp_strobe    (rsp_strobe),
      .rsp_symbol    (symbol),
      .rsp_invalid   (rsp_invalid)
   );

   assign rsp_symbol = $signed(symbol);

endmodule

>>> dv/jsu_result_checker.sv
// watches the request and result channels of the jacobi symbol unit,
// predicts each result from the accepted request and compares in order
module jsu_result_checker
   import jsu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [IN_W-1:0]   req_numerator,
   input  logic [IN_W-1:0]   req_modulus,
   input  logic              rsp_strobe,
   input  logic signed [1:0] rsp_symbol,
   input  logic              rsp_invalid,
   output int                error_count,
   output int                pending,
   output int                checked,
   output int                invalid_seen,
   output int                zero_seen,
   output int                pos_seen,
   output int                neg_seen
);

   typedef struct packed {
      logic signed [1:0] symbol;
      logic              invalid;
   } jacobi_result_type;

   jacobi_result_type expected_results[$];
   jacobi_result_type oldest;
   int errs, done_cnt, inv_cnt, zero_cnt, pos_cnt, neg_cnt;

   // jacobi symbol by the reciprocity loop, operands cut to WIDTH bits
   function automatic jacobi_result_type jacobi_of(input logic [IN_W-1:0] num_in,
                                                   input logic [IN_W-1:0] mod_in);
      longint unsigned mask, a, n, t;
      bit negate;
      jacobi_result_type r;
      mask = (WIDTH >= 64) ? ~64'd0 : ((64'd1 << WIDTH) - 64'd1);
      a = 64'(num_in) & mask;
      n = 64'(mod_in) & mask;
      negate = 1'b0;
      r.symbol = SYM_ZERO;
      r.invalid = 1'b0;
      // even or zero modulus is rejected
      if (n == 0 || n[0] == 1'b0) begin
         r.invalid = 1'b1;
         return r;
      end
      a = a % n;
      while (a != 0) begin
         // strip twos, sign flips when modulus is 3 or 5 mod 8
         while (a[0] == 1'b0) begin
            a = a >> 1;
            if (n[2:0] == MOD8_THREE || n[2:0] == MOD8_FIVE)
               negate = !negate;
         end
         // reciprocity swap
         t = a;
         a = n;
         n = t;
         if (a[1:0] == MOD4_THREE && n[1:0] == MOD4_THREE)
            negate = !negate;
         a = a % n;
      end
      // a final modulus above one means a common factor
      if (n == 1)
         r.symbol = negate ? SYM_NEG : SYM_POS;
      return r;
   endfunction

   // results are compared before the request of the same edge is queued
   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         errs = 0;
         done_cnt = 0;
         inv_cnt = 0;
         zero_cnt = 0;
         pos_cnt = 0;
         neg_cnt = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               errs++;
               $display("%0t: result with no request waiting: symbol %0d invalid %0b",
                        $time, rsp_symbol, rsp_invalid);
            end else begin
               oldest = expected_results.pop_front();
               done_cnt++;
               if (rsp_symbol !== oldest.symbol || rsp_invalid !== oldest.invalid)
                  errs++;
               if (rsp_symbol !== oldest.symbol)
                  $display("%0t: symbol mismatch: expected %0d, got %0d",
                           $time, oldest.symbol, rsp_symbol);
               if (rsp_invalid !== oldest.invalid)
                  $display("%0t: invalid mismatch: expected %0b, got %0b",
                           $time, oldest.invalid, rsp_invalid);
               if (oldest.invalid)
                  inv_cnt++;
               else if (oldest.symbol == SYM_ZERO)
                  zero_cnt++;
               else if (oldest.symbol == SYM_POS)
                  pos_cnt++;
               else
                  neg_cnt++;
            end
         end
         if (start && !busy)
            expected_results.push_back(jacobi_of(req_numerator, req_modulus));
      end
      error_count  <= errs;
      pending      <= expected_results.size();
      checked      <= done_cnt;
      invalid_seen <= inv_cnt;
      zero_seen    <= zero_cnt;
      pos_seen     <= pos_cnt;
      neg_seen     <= neg_cnt;
   end

endmodule

>>> dv/tb_jacobi_symbol_unit.sv
module tb_jacobi_symbol_unit;
   import jsu_pkg::*;

   localparam int STALL_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 2100;
   localparam int PHASE_ITEMS  = 145;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [IN_W-1:0]   req_numerator;
   logic [IN_W-1:0]   req_modulus;
   logic              rsp_strobe;
   logic signed [1:0] rsp_symbol;
   logic              rsp_invalid;

   int error_count, pending, checked;
   int invalid_seen, zero_seen, pos_seen, neg_seen;
   int idle_pct;
   int directed_sent, random_sent;
   int quiet_cycles;

   jacobi_symbol_unit uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_numerator (req_numerator),
      .req_modulus   (req_modulus),
      .rsp_strobe    (rsp_strobe),
      .rsp_symbol    (rsp_symbol),
      .rsp_invalid   (rsp_invalid)
   );

   jsu_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_numerator (req_numerator),
      .req_modulus   (req_modulus),
      .rsp_strobe    (rsp_strobe),
      .rsp_symbol    (rsp_symbol),
      .rsp_invalid   (rsp_invalid),
      .error_count   (error_count),
      .pending       (pending),
      .checked       (checked),
      .invalid_seen  (invalid_seen),
      .zero_seen     (zero_seen),
      .pos_seen      (pos_seen),
      .neg_seen      (neg_seen)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d results pending",
                  quiet_cycles, pending);
         $display("jacobi_symbol_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // operand of random bit length, so small and large sizes both occur
   function automatic logic [IN_W-1:0] rand_operand();
      return IN_W'($urandom) >> $urandom_range(0, IN_W - 1);
   endfunction

   // present one request, idling with noise on the data first
   task automatic send_request(input logic [IN_W-1:0] num, input logic [IN_W-1:0] modv);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         req_numerator <= IN_W'($urandom);
         req_modulus <= IN_W'($urandom);
         @(negedge clock);
      end
      start <= 1'b1;
      req_numerator <= num;
      req_modulus <= modv;
      do @(posedge clock); while (busy);
   endtask

   // hold off until every queued request has its result
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic send_directed(input logic [IN_W-1:0] num, input logic [IN_W-1:0] modv);
      send_request(num, modv);
      directed_sent++;
   endtask

   // random request mix: mostly odd moduli, some shared factors and rejects
   task automatic send_random();
      logic [IN_W-1:0] num, modv, f, hi;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         num = rand_operand();
         modv = rand_operand() | 1;
      end else if (pick < 77) begin
         f = $urandom_range(1, 127) * 2 + 1;
         hi = {IN_W{1'b1}} / f;
         modv = f * ($urandom_range(0, (hi - 1) / 2) * 2 + 1);
         num = f * $urandom_range(0, hi);
         if ($urandom_range(0, 1))
            modv = modv >> ($urandom_range(0, 12) * 2);
         modv = modv | 1;
      end else if (pick < 85) begin
         num = IN_W'($urandom);
         modv = ($urandom_range(0, 3) == 0) ? '0 : (IN_W'($urandom) & ~IN_W'(1));
      end else if (pick < 89) begin
         num = IN_W'($urandom);
         modv = 1;
      end else if (pick < 93) begin
         num = '0;
         modv = rand_operand() | 1;
      end else begin
         num = IN_W'($urandom);
         modv = IN_W'($urandom) | {1'b1, {(IN_W - 2){1'b0}}, 1'b1};
      end
      send_request(num, modv);
      random_sent++;
   endtask

   // stimulus
   initial begin
      start = 1'b0;
      req_numerator = '0;
      req_modulus = '0;
      reset = 1'b1;
      idle_pct = 0;
      directed_sent = 0;
      random_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero and even moduli
      send_directed(32'd0, 32'd0);
      send_directed(32'd5, 32'd0);
      send_directed(32'd7, 32'd8);
      send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      // modulus one
      send_directed(32'd0, 32'd1);
      send_directed(32'hFFFF_FFFF, 32'd1);
      // zero numerator and shared factors
      send_directed(32'd0, 32'd3);
      send_directed(32'd0, 32'hFFFF_FFFF);
      send_directed(32'd3, 32'd3);
      send_directed(32'd15, 32'd21);
      send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // factor of two rules and reciprocity
      send_directed(32'd2, 32'd7);
      send_directed(32'd2, 32'd3);
      send_directed(32'd2, 32'd5);
      send_directed(32'd2, 32'd15);
      send_directed(32'd3, 32'd7);
      send_directed(32'd7, 32'd3);
      // wide operands, long strip runs
      send_directed(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_directed(32'd1, 32'd4294967291);
      send_directed(32'd4294967290, 32'd4294967291);
      send_directed(32'h8000_0000, 32'd4294967291);
      send_directed(32'h5555_5555, 32'hAAAA_AAAB);
      send_directed(32'd1001, 32'd9907);
      drain();

      // random phases with different sender idling
      repeat (PHASE_ITEMS) send_random();
      drain();
      idle_pct = 59;
      repeat (PHASE_ITEMS) send_random();
      drain();
      idle_pct = 35;
      repeat (PHASE_ITEMS) send_random();
      drain();
      idle_pct = 0;
      repeat (PHASE_ITEMS) send_random();
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d requests: %0d directed, %0d random, sender idle 0/59/35/0 percent",
               directed_sent + random_sent, directed_sent, random_sent);
      $display("checked %0d results: %0d invalid, %0d zero, %0d plus one, %0d minus one",
               checked, invalid_seen, zero_seen, pos_seen, neg_seen);
      if (error_count == 0 && pending == 0) begin
         $display("jacobi_symbol_unit test passed");
      end else begin
         $display("jacobi_symbol_unit test failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/jsu_pkg.sv
design/jsu_datapath.sv
design/jsu_controller.sv
design/jacobi_symbol_unit.sv
dv/jsu_result_checker.sv
dv/tb_jacobi_symbol_unit.sv
